>>> design/pctbp_pkg.sv
// Package: shared types and constants of the per-client token bucket policer.
`default_nettype none
package pctbp_pkg;
   localparam logic [1:0] CMD_ADMIT  = 2'd0;
   localparam logic [1:0] CMD_TOTALS = 2'd1;
   localparam logic [1:0] CMD_DRAIN  = 2'd2;
   localparam logic [1:0] CMD_RATE   = 2'd3;
   localparam logic [19:0] RATE_MAX = 20'd1000000;
   localparam logic [20:0] RATE_MAX_S = 21'd1000000;
   localparam logic [47:0] US_PER_S = 48'd1000000;
   localparam logic [20:0] RATE_DEFAULT = 21'h1FFFFF;
   // Refill is el * rate / 8000: a shift by 6, then a divide by 125
   localparam logic [6:0]  KBIT_DIV  = 7'd125;
   localparam logic [17:0] RECIP_HI  = 18'd134218;    // ceil(2^24 / 125)
   localparam logic [24:0] RECIP_LO  = 25'd17179870;  // ceil(2^31 / 125)

   // Datapath commands issued by the controller
   typedef struct packed {
      logic load;       // capture request and start a scan
      logic scan_step;  // compare one entry
      logic alloc;      // write a fresh entry at the chosen slot
      logic rd_entry;   // read the chosen entry
      logic calc_rate;  // work out the rate and elapsed time
      logic mul_a;      // refill multiply
      logic div_hi;     // upper quotient part of the divide by 125
      logic div_mid;    // remainder of the upper part
      logic div_lo;     // lower quotient part
      logic update;     // write results back and form the response
   } cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic scan_done;
      logic hit;
   } stat_type;
endpackage
`default_nettype wire

>>> design/per_client_token_bucket_policer.sv
// Top level: per-client token bucket policer.
// Channel | Ports                  | Contents
// req     | req_tvalid/tready/tdata | cmd, client_addr, pkt_len, direction, now_us, override_rate
// rsp     | rsp_tvalid/tready/tdata | admitted, down_total, up_total, drained_bytes
// csr     | csr_wr_en/csr_wr_data   | default_rate_kbps
// One item at a time: a scan, then for admit allocate, read, rate, multiply,
// three divide steps and the response step; other commands skip the rate,
// multiply and divide steps. The block then returns to idle for the next transfer.
// Synchronous reset clears the valid bits, state and the default rate.
// A held response stalls the next item only at its final step, until taken.
`default_nettype none
module per_client_token_bucket_policer #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [119:0] req_tdata,  // cmd, client_addr, pkt_len, direction, now_us, override_rate
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [199:0]      rsp_tdata,  // admitted, down_total, up_total, drained_bytes
   input  wire logic         csr_wr_en,
   input  wire logic [19:0]  csr_wr_data
);
   import pctbp_pkg::*;
   cmd_type  cmd;
   stat_type stat;
   logic [19:0]  rate_ff;
   logic [192:0] word;

   // Hold the default rate
   always_ff @(posedge clock) begin
      if (reset) rate_ff <= '0;
      else if (csr_wr_en) rate_ff <= csr_wr_data;
   end

   assign rsp_tdata = {7'd0, word};

   pctbp_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_cmd(req_tdata[1:0]),
      .rsp_tvalid, .rsp_tready, .cmd, .stat
   );

   pctbp_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .stat, .default_rate(rate_ff),
      .req_cmd(req_tdata[1:0]), .req_addr(req_tdata[33:2]), .req_len(req_tdata[49:34]),
      .req_dir(req_tdata[50]), .req_now(req_tdata[98:51]), .req_ovr(req_tdata[119:99]),
      .rsp_word(word)
   );
endmodule
`default_nettype wire

>>> design/pctbp_datapath.sv
// Datapath: client table, bucket arithmetic and response register.
`default_nettype none
module pctbp_datapath #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pctbp_pkg::cmd_type   cmd,
   output pctbp_pkg::stat_type       stat,
   input  wire logic [19:0]       default_rate,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [31:0]       req_addr,
   input  wire logic [15:0]       req_len,
   input  wire logic              req_dir,
   input  wire logic [47:0]       req_now,
   input  wire logic [20:0]       req_ovr,
   output logic [192:0]           rsp_word
);
   import pctbp_pkg::*;
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // Table storage
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [31:0] addr_mem [TABLE_ENTRIES];
   logic [26:0] tok_mem [2*TABLE_ENTRIES];
   logic [47:0] time_mem [2*TABLE_ENTRIES];
   logic [20:0] ovr_mem [TABLE_ENTRIES];
   logic [63:0] meter_mem [TABLE_ENTRIES];
   logic [63:0] cum_mem [2*TABLE_ENTRIES];

   // Request registers
   logic [1:0]  op_ff;
   logic [31:0] key_ff;
   logic [15:0] len_ff;
   logic        dir_ff;
   logic [47:0] now_ff;
   logic [20:0] ovr_ff;

   // Scan state
   logic [CW-1:0] idx_ff;
   logic          hit_ff, free_ff, old_ok_ff;
   logic [IW-1:0] slot_ff, free_idx_ff, old_idx_ff;
   logic [47:0]   old_time_ff;

   // Working registers
   logic [26:0] tok_ff;
   logic [47:0] last_ff;
   logic [20:0] eovr_ff;
   logic [63:0] meter_ff, cum0_ff, cum1_ff;
   logic [19:0] rate_ff;
   logic [19:0] el_ff;
   logic        adv_ff;
   logic [33:0] prod_ff;   // el * rate / 64, at most 1.5625e10
   logic [9:0]  qh_ff;
   logic [23:0] nlo_ff;
   logic [26:0] quo_ff;
   logic [192:0] rsp_ff;

   logic [IW-1:0] cur;
   logic [IW:0]   bsel;
   logic [20:0]   rate_raw;
   logic [47:0]   el_full;
   logic [26:0]   bps;
   logic [39:0]   mprod;
   logic [34:0]   hmul;
   logic [16:0]   rh;
   logic [48:0]   lmul;
   logic [27:0]   tsum;
   logic [26:0]   tnew;
   logic [26:0]   tavail;
   logic          pass;
   logic [20:0]   ovr_sat;

   assign cur  = idx_ff[IW-1:0];
   assign bsel = {slot_ff, dir_ff};
   assign stat.scan_done = (idx_ff == CW'(TABLE_ENTRIES)) || hit_ff;
   assign stat.hit = hit_ff;
   assign rsp_word = rsp_ff;
   assign rate_raw = eovr_ff[20] ? {1'b0, default_rate} : eovr_ff;
   assign el_full = now_ff - last_ff;
   assign bps = 27'(rate_ff) * 27'(KBIT_DIV);
   assign mprod = 40'(el_ff) * 40'(rate_ff);
   assign hmul = 35'(prod_ff[33:17]) * 35'(RECIP_HI);
   assign rh = prod_ff[33:17] - 17'(qh_ff) * 17'(KBIT_DIV);
   assign lmul = 49'(nlo_ff) * 49'(RECIP_LO);
   assign tsum = {1'b0, tok_ff} + {1'b0, quo_ff};
   assign tnew = (tsum > {1'b0, bps}) ? bps : tsum[26:0];
   assign tavail = adv_ff ? tnew : tok_ff;
   assign pass = (rate_ff == '0) || (tavail >= 27'(len_ff));
   assign ovr_sat = (!req_ovr[20] && req_ovr > RATE_MAX_S) ? RATE_MAX_S : req_ovr;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.alloc) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   // Scan, bucket arithmetic and write-back
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_cmd; key_ff <= req_addr; len_ff <= req_len;
         dir_ff <= req_dir; now_ff <= req_now; ovr_ff <= ovr_sat;
         idx_ff <= '0; hit_ff <= 1'b0; free_ff <= 1'b0; old_ok_ff <= 1'b0;
         slot_ff <= '0; free_idx_ff <= '0; old_idx_ff <= '0; old_time_ff <= '0;
      end
      if (cmd.scan_step && !stat.scan_done) begin
         idx_ff <= idx_ff + 1'b1;
         if (valid_ff[cur]) begin
            if (addr_mem[cur] == key_ff) begin
               hit_ff <= 1'b1;
               slot_ff <= cur;
            end else if (!old_ok_ff || time_mem[{cur, 1'b0}] < old_time_ff) begin
               old_ok_ff <= 1'b1;
               old_idx_ff <= cur;
               old_time_ff <= time_mem[{cur, 1'b0}];
            end
         end else if (!free_ff) begin
            free_ff <= 1'b1;
            free_idx_ff <= cur;
         end
      end
      if (cmd.scan_step && stat.scan_done && !hit_ff) begin
         slot_ff <= free_ff ? free_idx_ff : old_idx_ff;
      end
      if (cmd.alloc) begin
         addr_mem[slot_ff] <= key_ff;
         ovr_mem[slot_ff] <= RATE_DEFAULT;
         meter_mem[slot_ff] <= '0;
         tok_mem[{slot_ff, 1'b0}] <= '0;  tok_mem[{slot_ff, 1'b1}] <= '0;
         time_mem[{slot_ff, 1'b0}] <= '0; time_mem[{slot_ff, 1'b1}] <= '0;
         cum_mem[{slot_ff, 1'b0}] <= '0;  cum_mem[{slot_ff, 1'b1}] <= '0;
      end
      if (cmd.rd_entry) begin
         tok_ff <= tok_mem[bsel];
         last_ff <= time_mem[bsel];
         eovr_ff <= ovr_mem[slot_ff];
         meter_ff <= meter_mem[slot_ff];
         cum0_ff <= cum_mem[{slot_ff, 1'b0}];
         cum1_ff <= cum_mem[{slot_ff, 1'b1}];
      end
      if (cmd.calc_rate) begin
         rate_ff <= (rate_raw > RATE_MAX_S) ? RATE_MAX : rate_raw[19:0];
         adv_ff <= now_ff > last_ff;
         el_ff <= (el_full > US_PER_S) ? US_PER_S[19:0] : el_full[19:0];
      end
      // Refill multiply, pre-shifted by the power-of-two part of 8000
      if (cmd.mul_a) begin
         prod_ff <= mprod[39:6];
      end
      // Divide by 125 in two reciprocal steps over the upper and lower halves
      if (cmd.div_hi) begin
         qh_ff <= hmul[33:24];
      end
      if (cmd.div_mid) begin
         nlo_ff <= {rh[6:0], prod_ff[16:0]};
      end
      if (cmd.div_lo) begin
         quo_ff <= {qh_ff, lmul[47:31]};
      end
      if (cmd.update) begin
         case (op_ff)
            CMD_ADMIT: begin
               rsp_ff <= {192'd0, pass};
               if (rate_ff == '0) begin
                  meter_mem[slot_ff] <= meter_ff + 64'(len_ff);
                  cum_mem[bsel] <= (dir_ff ? cum1_ff : cum0_ff) + 64'(len_ff);
               end else begin
                  if (adv_ff) time_mem[bsel] <= now_ff;
                  if (pass) begin
                     tok_mem[bsel] <= tavail - 27'(len_ff);
                     meter_mem[slot_ff] <= meter_ff + 64'(len_ff);
                     cum_mem[bsel] <= (dir_ff ? cum1_ff : cum0_ff) + 64'(len_ff);
                  end else if (adv_ff) begin
                     tok_mem[bsel] <= tnew;
                  end
               end
            end
            CMD_TOTALS: begin
               rsp_ff <= hit_ff ? {64'd0, cum1_ff, cum0_ff, 1'b0} : '0;
            end
            CMD_DRAIN: begin
               rsp_ff <= hit_ff ? {meter_ff, 128'd0, 1'b0} : '0;
               if (hit_ff) meter_mem[slot_ff] <= '0;
            end
            default: begin
               rsp_ff <= '0;
               ovr_mem[slot_ff] <= ovr_ff;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

>>> design/pctbp_ctrl.sv
// Controller: sequences scan, allocation, refill and response handshake.
`default_nettype none
module pctbp_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [1:0]      req_cmd,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output pctbp_pkg::cmd_type   cmd,
   input  wire pctbp_pkg::stat_type stat
);
   import pctbp_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_ALLOC = 4'd2, S_READ = 4'd3,
                          S_RATE = 4'd4, S_MUL = 4'd5, S_DIVH = 4'd6, S_DIVM = 4'd7,
                          S_DIVL = 4'd8, S_DONE = 4'd9;
   logic [3:0] state_ff, state_in;
   logic [1:0] op_ff;
   logic       out_ff, out_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !rsp_tready;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               if (stat.hit) state_in = S_READ;
               else if (op_ff == CMD_ADMIT || op_ff == CMD_RATE) state_in = S_ALLOC;
               else state_in = S_DONE;
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.rd_entry = 1'b1;
            state_in = (op_ff == CMD_ADMIT) ? S_RATE : S_DONE;
         end
         S_RATE: begin
            cmd.calc_rate = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_a = 1'b1;
            state_in = S_DIVH;
         end
         S_DIVH: begin
            cmd.div_hi = 1'b1;
            state_in = S_DIVM;
         end
         S_DIVM: begin
            cmd.div_mid = 1'b1;
            state_in = S_DIVL;
         end
         S_DIVL: begin
            cmd.div_lo = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Wait here while the previous response is still held
            if (!out_ff || rsp_tready) begin
               cmd.update = 1'b1;
               out_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
      if (cmd.load) op_ff <= req_cmd;
   end
endmodule
`default_nettype wire
